// ----- rtl/wsg_pkg.sv -----
// Shared types, constants and elaboration-time tables for the waveform sample generator.
// Used by wsg_regs, wsg_divider and waveform_sample_generator; depends on nothing.
package wsg_pkg;

	localparam int MAX_SAMPLES    = 1024;
	localparam int DAC_FULL_SCALE = 4095;
	localparam int MIN_SAMPLES    = 2;
	localparam int AMP_FULL       = 100;

	// field and register widths
	localparam int SAMPLE_W = 12;
	localparam int WSEL_W   = 2;
	localparam int AMP_W    = 7;
	localparam int CNT_W    = 11;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int RIDX_W   = 2;

	// datapath widths
	localparam int IDX_W      = $clog2(MAX_SAMPLES);
	localparam int N_W        = $clog2(MAX_SAMPLES + 2);
	localparam int CL_W       = (CNT_W > N_W) ? CNT_W : N_W;
	localparam int MAXV_W     = $clog2(DAC_FULL_SCALE + 1);
	localparam int PHASE_W    = 10;
	localparam int QS_W       = 15;
	localparam int SB_W       = 17;
	localparam int SINE_SHIFT = 16;
	localparam int Q_W        = (MAXV_W > PHASE_W) ? MAXV_W : PHASE_W;
	localparam int DIVD_W     = (MAXV_W + N_W > IDX_W + PHASE_W) ? MAXV_W + N_W
	                                                              : IDX_W + PHASE_W;
	localparam int CMP_W      = (DIVD_W > N_W + Q_W - 1) ? DIVD_W : N_W + Q_W - 1;
	localparam int QCNT_W     = $clog2(Q_W);
	localparam int MULA_W     = (SB_W > N_W) ? SB_W : N_W;
	localparam int PROD_W     = MULA_W + MAXV_W;
	localparam int SUM_W      = (MAXV_W + 1 > SAMPLE_W) ? MAXV_W + 1 : SAMPLE_W;

	localparam logic [QS_W-1:0] QS_MAX  = 15'd32767;
	localparam logic [SB_W-1:0] SB_MID  = 17'd32768;
	localparam logic [63:0]     PI_Q60  = 64'h3243F6A8885A308D;

	// register map, word index into paddr
	localparam logic [RIDX_W-1:0] REG_WAVE  = 2'd0;
	localparam logic [RIDX_W-1:0] REG_AMP   = 2'd1;
	localparam logic [RIDX_W-1:0] REG_COUNT = 2'd2;

	typedef enum logic [WSEL_W-1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAWTOOTH = 2'd2,
		WAVE_SQUARE   = 2'd3
	} wave_t;

	typedef struct packed {
		wave_t             wave;
		logic [AMP_W-1:0]  amp;
		logic [CNT_W-1:0]  count;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [N_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [Q_W-1:0]    quotient;
	} div_rsp_t;

	// (a*b) >> 60, elaboration only
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// term / ((2n)*(2n+1)) for Taylor step n, elaboration only
	function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
		logic [63:0] q;
		unique case (n)
			1:       q = t / 64'd6;
			2:       q = t / 64'd20;
			3:       q = t / 64'd42;
			4:       q = t / 64'd72;
			5:       q = t / 64'd110;
			6:       q = t / 64'd156;
			7:       q = t / 64'd210;
			8:       q = t / 64'd272;
			9:       q = t / 64'd342;
			10:      q = t / 64'd420;
			11:      q = t / 64'd506;
			12:      q = t / 64'd600;
			13:      q = t / 64'd702;
			default: q = t / 64'd812;
		endcase
		return q;
	endfunction

	// round(32767*sin(pi*k/512)) for k in 0..255, Taylor series in Q60
	typedef logic [QS_W-1:0] qsine_tab_t [256];

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t  tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		for (int k = 0; k < 256; k++) begin
			x = (PI_Q60 >> 9) * 64'(k) + (((PI_Q60 & 64'd511) * 64'(k)) >> 9);
			x2 = mul_q60(x, x);
			term = x;
			sum = x;
			for (int n = 1; n <= 14; n++) begin
				term = taylor_div(mul_q60(term, x2), n);
				if ((n & 1) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			r = (((sum >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
			tab[k] = r[QS_W-1:0];
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE = build_qsine();

	// peak code per amplitude register value, clamped at full scale
	typedef logic [MAXV_W-1:0] maxv_tab_t [2**AMP_W];

	function automatic maxv_tab_t build_maxv();
		maxv_tab_t tab;
		int        am;
		for (int a = 0; a < 2**AMP_W; a++) begin
			am = (a > AMP_FULL) ? AMP_FULL : a;
			tab[a] = MAXV_W'((DAC_FULL_SCALE * am) / AMP_FULL);
		end
		return tab;
	endfunction

	localparam maxv_tab_t MAXV_TAB = build_maxv();

endpackage

// ----- rtl/wsg_regs.sv -----
// Configuration registers behind an APB-style port: waveform, amplitude, sample count.
// Depends on wsg_pkg.
module wsg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wsg_pkg::ADDR_W-1:0]  paddr,
	input  logic [wsg_pkg::DATA_W-1:0]  pwdata,
	output logic [wsg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output wsg_pkg::cfg_t               cfg
);
	import wsg_pkg::*;

	cfg_t              cfg_q;
	logic              wr_en;
	logic [RIDX_W-1:0] ridx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign ridx   = paddr[RIDX_W+1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave  <= WAVE_SINE;
			cfg_q.amp   <= AMP_W'(AMP_FULL);
			cfg_q.count <= CNT_W'(MAX_SAMPLES);
		end else if (wr_en) begin
			unique case (ridx)
				REG_WAVE:  cfg_q.wave  <= wave_t'(pwdata[WSEL_W-1:0]);
				REG_AMP:   cfg_q.amp   <= pwdata[AMP_W-1:0];
				REG_COUNT: cfg_q.count <= pwdata[CNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_WAVE:  prdata = DATA_W'(cfg_q.wave);
			REG_AMP:   prdata = DATA_W'(cfg_q.amp);
			REG_COUNT: prdata = DATA_W'(cfg_q.count);
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- rtl/wsg_divider.sv -----
// Restoring serial divider, one quotient bit per cycle, Q_W steps per division.
// Caller guarantees the quotient fits in Q_W bits. Depends on wsg_pkg.
module wsg_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  wsg_pkg::div_req_t  req,
	output wsg_pkg::div_rsp_t  rsp
);
	import wsg_pkg::*;

	logic [CMP_W-1:0]  rem_q;
	logic [CMP_W-1:0]  dsh_q;
	logic [Q_W-1:0]    quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(Q_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// divisor starts aligned to the top quotient bit and walks down
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= CMP_W'(req.dividend);
			dsh_q <= CMP_W'(req.divisor) << (Q_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !req.start) |=> (done_q && !busy_q))
		else $error("divider did not finish after last step");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while still busy");

endmodule

// ----- rtl/waveform_sample_generator.sv -----
// Waveform sample generator: one tick item in, one DAC sample out per period position.
// Each item passes through prep, setup, the serial divider (not for square; 12 quotient steps),
// a table step for sine only, then the final step; a new item is taken only once the last
// sample has entered the output register. Items with tick low are taken while idle and give no result.
// Reset (arst_n, async low) restores the register defaults and sample index 0.
// Depends on wsg_pkg, wsg_regs, wsg_divider.
module waveform_sample_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wsg_pkg::ADDR_W-1:0]    paddr,
	input  logic [wsg_pkg::DATA_W-1:0]    pwdata,
	output logic [wsg_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          tick,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wsg_pkg::SAMPLE_W-1:0]  sample_value,
	output logic                          period_end
);
	import wsg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PREP  = 6'b000010,
		ST_SETUP = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SINE  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [IDX_W-1:0]  idx_q;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    half_q;
	logic [IDX_W-1:0]  i_q;
	logic [MAXV_W-1:0] maxv_q;
	wave_t             wave_q;
	logic              pend_q;
	logic [SB_W-1:0]   sb_q;

	logic              out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic              period_end_q;

	logic [CL_W-1:0]   cnt_ext;
	logic [N_W-1:0]    n_c;
	logic [IDX_W-1:0]  i_c;
	logic [IDX_W-1:0]  i_next;
	logic              last_c;

	logic              tri_fall;
	logic [MULA_W-1:0] mul_a;
	logic [PROD_W-1:0] prod;

	logic [PHASE_W-1:0] phase;
	logic [7:0]        qk;
	logic [QS_W-1:0]   qs;
	logic [SB_W-1:0]   sb_c;

	logic [MAXV_W-1:0] wave_v;
	logic [MAXV_W-1:0] offset;
	logic [SUM_W-1:0]  sum;
	logic              out_load;

	wsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wsg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// clamp the period length, restart the period if the count shrank under the index
	always_comb begin
		cnt_ext = CL_W'(cfg.count);
		priority if (cnt_ext < CL_W'(MIN_SAMPLES)) begin
			n_c = N_W'(MIN_SAMPLES);
		end else if (cnt_ext > CL_W'(MAX_SAMPLES)) begin
			n_c = N_W'(MAX_SAMPLES);
		end else begin
			n_c = N_W'(cnt_ext);
		end
		i_c    = (N_W'(idx_q) >= n_c) ? '0 : idx_q;
		last_c = (N_W'(i_c) == n_c - 1'b1);
		i_next = last_c ? '0 : i_c + 1'b1;
	end

	// shared multiplier: dividend in setup, sine scaling in the final step
	always_comb begin
		tri_fall = N_W'(i_q) > half_q;
		if (state_q == ST_FIN) begin
			mul_a = MULA_W'(sb_q);
		end else if (wave_q == WAVE_TRIANGLE && tri_fall) begin
			mul_a = MULA_W'(n_q - N_W'(i_q));
		end else begin
			mul_a = MULA_W'(i_q);
		end
		prod = PROD_W'(mul_a) * PROD_W'(maxv_q);
	end

	always_comb begin
		div_req.start = (state_q == ST_SETUP) && (wave_q != WAVE_SQUARE);
		unique case (wave_q)
			WAVE_SINE: begin
				div_req.dividend = DIVD_W'({i_q, {PHASE_W{1'b0}}});
				div_req.divisor  = n_q + 1'b1;
			end
			WAVE_TRIANGLE: begin
				div_req.dividend = DIVD_W'(prod);
				div_req.divisor  = half_q;
			end
			WAVE_SAWTOOTH: begin
				div_req.dividend = DIVD_W'(prod);
				div_req.divisor  = n_q - 1'b1;
			end
			WAVE_SQUARE: begin
				div_req.dividend = '0;
				div_req.divisor  = half_q;
			end
		endcase
	end

	// quarter-wave table folding; the exact peak sits outside the table
	always_comb begin
		phase = div_rsp.quotient[PHASE_W-1:0];
		qk    = phase[8] ? 8'd0 - phase[7:0] : phase[7:0];
		qs    = (phase[8] && phase[7:0] == 8'd0) ? QS_MAX : QSINE[qk];
		sb_c  = phase[9] ? SB_MID - SB_W'(qs) : SB_MID + SB_W'(qs);
	end

	always_comb begin
		unique case (wave_q)
			WAVE_SINE:     wave_v = prod[SINE_SHIFT +: MAXV_W];
			WAVE_TRIANGLE: wave_v = div_rsp.quotient[MAXV_W-1:0];
			WAVE_SAWTOOTH: wave_v = div_rsp.quotient[MAXV_W-1:0];
			WAVE_SQUARE:   wave_v = (N_W'(i_q) < half_q) ? maxv_q : '0;
		endcase
		offset   = (MAXV_W'(DAC_FULL_SCALE) - maxv_q) >> 1;
		sum      = SUM_W'(wave_v) + SUM_W'(offset);
		out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && tick) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					idx_q   <= i_next;
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= (wave_q == WAVE_SQUARE) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= (wave_q == WAVE_SINE) ? ST_SINE : ST_FIN;
					end
				end
				ST_SINE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			n_q    <= n_c;
			half_q <= n_c >> 1;
			i_q    <= i_c;
			maxv_q <= MAXV_TAB[cfg.amp];
			wave_q <= cfg.wave;
			pend_q <= last_c;
		end
		if (state_q == ST_SINE) begin
			sb_q <= sb_c;
		end
		if (out_load) begin
			sample_q     <= sum[SAMPLE_W-1:0];
			period_end_q <= pend_q;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;
	assign period_end   = period_end_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy) else $error("divider busy while taking an item");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result registered outside the final step");

	a_index_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SETUP) |-> (N_W'(i_q) < n_q))
		else $error("sample index outside the period");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV)) else $error("quotient arrived unexpectedly");

endmodule
